// File: src/assert_macros.svh
// assertion helpers included by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define SLC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define SLC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/slc_pkg.sv
package slc_pkg;

  localparam int COORD_WIDTH_DEF = 32;

  localparam int IN_DATA_W   = 128;
  localparam int OUT_DATA_W  = 376;
  localparam int OUT_PAD_W   = 6;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] CFG_RATIO_MODE  = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_WORLD_SCALE = 8'd1;
  localparam logic [31:0]            WORLD_SCALE_RST = 32'h0001_0000;

  // square root: radicand is the 66-bit sum of squares shifted up 30 bits
  localparam int SUM_W     = 66;
  localparam int FRAC_SH   = 30;
  localparam int SQ_RAD_W  = SUM_W + FRAC_SH;
  localparam int ROOT_W    = SQ_RAD_W / 2;
  localparam int SQ_REM_W  = ROOT_W + 2;
  localparam int SQ_CELLS  = ROOT_W;

  // reciprocal: 2^63 / root, restoring divide one quotient bit per cell
  localparam int INV_W     = 48;
  localparam int DIV_CELLS = 64;
  localparam int LINE_LEN  = SQ_CELLS + DIV_CELLS;

  localparam logic [INV_W-1:0] INV_MAX = {INV_W{1'b1}};
  localparam logic [63:0]      C_ONE   = 64'h0000_0001_0000_0000;

  typedef struct packed {
    logic [SQ_REM_W-1:0] rem;
    logic [ROOT_W-1:0]   root;
    logic [SQ_RAD_W-1:0] rad;
  } sqrt_cell_t;

  typedef struct packed {
    logic [INV_W-1:0]  rem;
    logic [INV_W-1:0]  quo;
    logic              ovf;
    logic [ROOT_W-1:0] dsr;
  } div_cell_t;

  typedef struct packed {
    logic [31:0] min_x;
    logic [31:0] max_x;
    logic [31:0] min_z;
    logic [31:0] max_z;
    logic [32:0] coef_a;
    logic [32:0] coef_b;
    logic [63:0] coef_c;
    logic [31:0] a_mag;
    logic [31:0] b_mag;
    logic        zero;
  } side_t;

  typedef struct packed {
    logic [31:0]      min_x;
    logic [31:0]      max_x;
    logic [31:0]      min_z;
    logic [31:0]      max_z;
    logic [32:0]      coef_a;
    logic [32:0]      coef_b;
    logic [63:0]      coef_c;
    logic [INV_W-1:0] inv_length;
    logic [31:0]      sine_term;
    logic [31:0]      cosine_term;
    logic             zero_length;
  } res_t;

endpackage

// File: src/segment_line_coefficients.sv
// channel | dir | handshake                 | payload
// in_     | in  | in_tvalid / in_tready     | in_tdata: first_x, first_z, second_x, second_z
// out_    | out | out_tvalid / out_tready   | out_tdata: box, coef a b c, inv_length, terms;
//         |     |                           | out_tuser: zero_length
// cfg_    | in  | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// one segment per cycle in and out while the receiver keeps out_tready high
// pipeline: 5 front stages, 48 square root cells, 64 divide cells, 2 term stages, output reg
// the pipe moves as a whole; a two-entry output (register plus skid) lets it run on while
// one result waits, and in_tready drops only while a second result sits in the skid
// rst_n is synchronous and clears all valid flags and the config registers
// cfg_ready is always high; writes take effect on the next cycle
module segment_line_coefficients #(
  parameter int COORD_WIDTH = slc_pkg::COORD_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // first_x, first_z, second_x, second_z (32 bits each)
  input  logic [slc_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // min_x, max_x, min_z, max_z (32), coef_a, coef_b (33), coef_c (64),
  // inv_length (48), sine_term, cosine_term (32), zero fill (6)
  output logic [slc_pkg::OUT_DATA_W-1:0]  out_tdata,
  // zero_length
  output logic [0:0]                      out_tuser,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [slc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [slc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import slc_pkg::*;

  `include "assert_macros.svh"

  localparam int CW = COORD_WIDTH;
  localparam int PW = CW + 33;

  // config registers
  logic        ratio_mode_r;
  logic [31:0] world_scale_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ratio_mode_r  <= 1'b0;
      world_scale_r <= WORLD_SCALE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_RATIO_MODE:  ratio_mode_r  <= cfg_data[0];
        CFG_WORLD_SCALE: world_scale_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // whole pipe advances unless the skid is holding a result
  logic ov_r, sv_r;
  logic en;
  logic in_acc;

  assign en        = !sv_r;
  assign in_tready = en;
  assign in_acc    = in_tvalid && en;

  // stage 1: take low coordinate bits, multiply by world scale
  logic signed [CW-1:0] crd [4];
  logic                 s1_v_r;
  logic signed [CW-1:0] s1_crd_r [4];
  logic signed [PW-1:0] s1_prd_r [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      crd[i] = in_tdata[32*i +: CW];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        s1_crd_r[i] <= crd[i];
        s1_prd_r[i] <= crd[i] * $signed({1'b0, world_scale_r});
      end
    end
  end

  // stage 2: ratio mode: drop 16 fraction bits (floor), saturate to coord range; else raw
  function automatic logic signed [CW-1:0] sat_coord(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] s;
    s = p >>> 16;
    if (s[PW-1:CW-1] == {(PW-CW+1){s[PW-1]}}) begin
      return s[CW-1:0];
    end else if (s[PW-1]) begin
      return {1'b1, {(CW-1){1'b0}}};
    end else begin
      return {1'b0, {(CW-1){1'b1}}};
    end
  endfunction

  logic                 s2_v_r;
  logic signed [CW-1:0] s2_crd_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        s2_crd_r[i] <= ratio_mode_r ? sat_coord(s1_prd_r[i]) : s1_crd_r[i];
      end
    end
  end

  // stage 3: order endpoints by x (tie takes the second point first), box, a and b
  logic signed [CW-1:0] x1, z1, x2, z2, zmn, zmx;
  logic                 s3_v_r;
  logic signed [CW-1:0] s3_x1_r, s3_z1_r, s3_x2_r, s3_z2_r, s3_zmn_r, s3_zmx_r;
  logic signed [CW:0]   s3_a_r, s3_b_r;

  always_comb begin
    if (s2_crd_r[0] < s2_crd_r[2]) begin
      x1 = s2_crd_r[0]; z1 = s2_crd_r[1]; x2 = s2_crd_r[2]; z2 = s2_crd_r[3];
    end else begin
      x1 = s2_crd_r[2]; z1 = s2_crd_r[3]; x2 = s2_crd_r[0]; z2 = s2_crd_r[1];
    end
    if (s2_crd_r[1] < s2_crd_r[3]) begin
      zmn = s2_crd_r[1]; zmx = s2_crd_r[3];
    end else begin
      zmn = s2_crd_r[3]; zmx = s2_crd_r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_x1_r  <= x1;
      s3_z1_r  <= z1;
      s3_x2_r  <= x2;
      s3_z2_r  <= z2;
      s3_zmn_r <= zmn;
      s3_zmx_r <= zmx;
      s3_a_r   <= (CW+1)'(z2) - (CW+1)'(z1);
      s3_b_r   <= (CW+1)'(x1) - (CW+1)'(x2);
    end
  end

  // stage 4: cross products, squares, magnitudes
  logic signed [2*CW+1:0] aa_f, bb_f;
  logic signed [CW:0]     a_neg, b_neg;
  logic                   s4_v_r;
  logic signed [2*CW-1:0] s4_p1_r, s4_p2_r;
  logic [2*CW-1:0]        s4_aa_r, s4_bb_r;
  logic [CW-1:0]          s4_am_r, s4_bm_r;
  logic signed [CW-1:0]   s4_mnx_r, s4_mxx_r, s4_zmn_r, s4_zmx_r;
  logic signed [CW:0]     s4_a_r, s4_b_r;
  logic                   s4_zero_r;

  always_comb begin
    aa_f  = s3_a_r * s3_a_r;
    bb_f  = s3_b_r * s3_b_r;
    a_neg = -s3_a_r;
    b_neg = -s3_b_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (en) begin
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_p1_r   <= s3_x2_r * s3_z1_r;
      s4_p2_r   <= s3_x1_r * s3_z2_r;
      s4_aa_r   <= aa_f[2*CW-1:0];
      s4_bb_r   <= bb_f[2*CW-1:0];
      s4_am_r   <= s3_a_r[CW] ? a_neg[CW-1:0] : s3_a_r[CW-1:0];
      s4_bm_r   <= s3_b_r[CW] ? b_neg[CW-1:0] : s3_b_r[CW-1:0];
      s4_mnx_r  <= s3_x1_r;
      s4_mxx_r  <= s3_x2_r;
      s4_zmn_r  <= s3_zmn_r;
      s4_zmx_r  <= s3_zmx_r;
      s4_a_r    <= s3_a_r;
      s4_b_r    <= s3_b_r;
      s4_zero_r <= (s3_a_r == '0) && (s3_b_r == '0);
    end
  end

  // stage 5: c, sum of squares; start of the side line and the radicand
  logic [2*CW:0]       ssum;
  logic [SUM_W-1:0]    s66;
  side_t               side0;
  logic [LINE_LEN:0]   vl_r;
  side_t               sd_r [LINE_LEN+1];
  logic [SQ_RAD_W-1:0] s5_rad_r;

  always_comb begin
    ssum         = {1'b0, s4_aa_r} + {1'b0, s4_bb_r};
    s66          = SUM_W'(ssum);
    side0.min_x  = 32'(s4_mnx_r);
    side0.max_x  = 32'(s4_mxx_r);
    side0.min_z  = 32'(s4_zmn_r);
    side0.max_z  = 32'(s4_zmx_r);
    side0.coef_a = 33'(s4_a_r);
    side0.coef_b = 33'(s4_b_r);
    side0.coef_c = 64'(s4_p1_r) - 64'(s4_p2_r);
    side0.a_mag  = 32'(s4_am_r);
    side0.b_mag  = 32'(s4_bm_r);
    side0.zero   = s4_zero_r;
  end

  // valid and side data travel beside the cell chains
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vl_r <= '0;
    end else if (en) begin
      vl_r <= {vl_r[LINE_LEN-1:0], s4_v_r};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd_r[0]  <= side0;
      s5_rad_r <= {s66, {FRAC_SH{1'b0}}};
      for (int k = 0; k < LINE_LEN; k++) begin
        sd_r[k+1] <= sd_r[k];
      end
    end
  end

  // square root chain, one root bit per cell
  sqrt_cell_t sq_w [SQ_CELLS+1];

  assign sq_w[0] = '{rem: '0, root: '0, rad: s5_rad_r};

  for (genvar i = 0; i < SQ_CELLS; i++) begin : g_sqrt
    slc_sqrt_cell u_cell (
      .clk (clk),
      .en  (en),
      .d_i (sq_w[i]),
      .d_o (sq_w[i+1])
    );
  end

  // reciprocal chain: 2^63 / root, one quotient bit per cell
  div_cell_t dv_w [DIV_CELLS+1];

  assign dv_w[0] = '{rem: '0, quo: '0, ovf: 1'b0, dsr: sq_w[SQ_CELLS].root};

  for (genvar j = 0; j < DIV_CELLS; j++) begin : g_div
    slc_div_cell u_cell (
      .clk     (clk),
      .en      (en),
      .num_bit ((j == 0) ? 1'b1 : 1'b0),
      .d_i     (dv_w[j]),
      .d_o     (dv_w[j+1])
    );
  end

  // term stage 1: saturate reciprocal, split products over two 24-bit halves
  logic [INV_W-1:0] inv;
  logic             t1_v_r;
  side_t            t1_side_r;
  logic [INV_W-1:0] t1_inv_r;
  logic [55:0]      t1_alo_r, t1_ahi_r, t1_blo_r, t1_bhi_r;

  assign inv = dv_w[DIV_CELLS].ovf ? INV_MAX : dv_w[DIV_CELLS].quo;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_v_r <= 1'b0;
    end else if (en) begin
      t1_v_r <= vl_r[LINE_LEN];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1_side_r <= sd_r[LINE_LEN];
      t1_inv_r  <= inv;
      t1_alo_r  <= sd_r[LINE_LEN].a_mag * inv[23:0];
      t1_ahi_r  <= sd_r[LINE_LEN].a_mag * inv[47:24];
      t1_blo_r  <= sd_r[LINE_LEN].b_mag * inv[23:0];
      t1_bhi_r  <= sd_r[LINE_LEN].b_mag * inv[47:24];
    end
  end

  // term stage 2: floor(|coef| * inv / 2^18), saturated, sign applied
  function automatic logic [30:0] term_mag(input logic [55:0] lo, input logic [55:0] hi);
    logic [80:0] p;
    p = {25'b0, lo} + {1'b0, hi, 24'b0};
    return (|p[80:49]) ? {31{1'b1}} : p[48:18];
  endfunction

  logic [31:0] smag, cmag;
  logic        sine_neg;
  res_t        res;
  logic        pv_r;
  res_t        p_r;

  always_comb begin
    smag     = {1'b0, term_mag(t1_blo_r, t1_bhi_r)};
    cmag     = {1'b0, term_mag(t1_alo_r, t1_ahi_r)};
    // -b*f, flipped again when a is negative
    sine_neg = (!t1_side_r.coef_b[32] && (t1_side_r.coef_b != '0)) != t1_side_r.coef_a[32];
    res.min_x  = t1_side_r.min_x;
    res.max_x  = t1_side_r.max_x;
    res.min_z  = t1_side_r.min_z;
    res.max_z  = t1_side_r.max_z;
    res.coef_a = t1_side_r.coef_a;
    res.coef_b = t1_side_r.coef_b;
    res.zero_length = t1_side_r.zero;
    if (t1_side_r.zero) begin
      // degenerate segment
      res.coef_c      = C_ONE;
      res.inv_length  = INV_MAX;
      res.sine_term   = '0;
      res.cosine_term = '0;
    end else begin
      res.coef_c      = t1_side_r.coef_c;
      res.inv_length  = t1_inv_r;
      res.sine_term   = sine_neg ? (~smag + 32'd1) : smag;
      res.cosine_term = cmag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else if (en) begin
      pv_r <= t1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= res;
    end
  end

  // output register plus skid
  logic ov_nxt, sv_nxt;
  res_t ob_r, ob_nxt, sk_r, sk_nxt;

  always_comb begin
    ov_nxt = ov_r;
    sv_nxt = sv_r;
    ob_nxt = ob_r;
    sk_nxt = sk_r;
    if (sv_r) begin
      if (out_tready) begin
        ob_nxt = sk_r;
        sv_nxt = 1'b0;
      end
    end else if (ov_r && !out_tready) begin
      // output busy: park the beat leaving the pipe
      if (pv_r) begin
        sk_nxt = p_r;
        sv_nxt = 1'b1;
      end
    end else begin
      ov_nxt = pv_r;
      ob_nxt = p_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
      sv_r <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
      sv_r <= sv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ob_r <= ob_nxt;
    sk_r <= sk_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tuser  = ob_r.zero_length;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, ob_r.cosine_term, ob_r.sine_term, ob_r.inv_length,
                       ob_r.coef_c, ob_r.coef_b, ob_r.coef_a, ob_r.max_z, ob_r.min_z,
                       ob_r.max_x, ob_r.min_x};

  `SLC_ASSERT(a_skid_behind_out, sv_r |-> ov_r, "skid holds a beat while output is empty")
  `SLC_ASSERT(a_skid_fill, $rose(sv_r) |-> $past(ov_r && !out_tready), "skid filled without stall")
  `SLC_ASSERT(a_zero_inv, ov_r && ob_r.zero_length |-> ob_r.inv_length == INV_MAX, "zero length inv")
  `SLC_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !ov_r && !sv_r, "output not empty after reset")

endmodule

// File: src/slc_sqrt_cell.sv
module slc_sqrt_cell (
  input  logic                clk,
  input  logic                en,
  input  slc_pkg::sqrt_cell_t d_i,
  output slc_pkg::sqrt_cell_t d_o
);
  import slc_pkg::*;

  logic [SQ_REM_W+1:0] rem_sh;
  logic [SQ_REM_W+1:0] trial;
  logic [SQ_REM_W+1:0] diff;
  logic                ge;
  sqrt_cell_t          d_nxt;
  sqrt_cell_t          d_r;

  // one root bit: bring in two radicand bits, try 4r+1
  always_comb begin
    rem_sh     = {d_i.rem, d_i.rad[SQ_RAD_W-1 -: 2]};
    trial      = {2'b00, d_i.root, 2'b01};
    diff       = rem_sh - trial;
    ge         = (rem_sh >= trial);
    d_nxt.rad  = {d_i.rad[SQ_RAD_W-3:0], 2'b00};
    d_nxt.root = {d_i.root[ROOT_W-2:0], ge};
    d_nxt.rem  = ge ? diff[SQ_REM_W-1:0] : rem_sh[SQ_REM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign d_o = d_r;

endmodule

// File: src/slc_div_cell.sv
module slc_div_cell (
  input  logic               clk,
  input  logic               en,
  input  logic               num_bit,
  input  slc_pkg::div_cell_t d_i,
  output slc_pkg::div_cell_t d_o
);
  import slc_pkg::*;

  logic [INV_W:0] rs;
  logic [INV_W:0] dv;
  logic [INV_W:0] diff;
  logic           ge;
  div_cell_t      d_nxt;
  div_cell_t      d_r;

  // one restoring step, quotient bits that fall off the top mark overflow
  always_comb begin
    rs        = {d_i.rem, num_bit};
    dv        = {1'b0, d_i.dsr};
    diff      = rs - dv;
    ge        = (rs >= dv);
    d_nxt.dsr = d_i.dsr;
    d_nxt.rem = ge ? diff[INV_W-1:0] : rs[INV_W-1:0];
    d_nxt.quo = {d_i.quo[INV_W-2:0], ge};
    d_nxt.ovf = d_i.ovf | d_i.quo[INV_W-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign d_o = d_r;

endmodule

// File: test/segment_line_coefficients_tb.sv
module segment_line_coefficients_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import slc_pkg::*;

  // register index that the block does not decode, writes to it must be dropped
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 8'd7;
  localparam int LATENCY = 120;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic signed [31:0] ax;
    logic signed [31:0] az;
    logic signed [31:0] bx;
    logic signed [31:0] bz;
  } segment_t;

  // keeps the expected line records of segments in flight, oldest first
  class line_scoreboard;
    res_t        pending[$];
    int          errors;
    logic        ratio_on;
    logic [31:0] scale;

    function new();
      errors = 0;
      ratio_on = 1'b0;
      scale = WORLD_SCALE_RST;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [31:0] data);
      if (idx == CFG_RATIO_MODE)
        ratio_on = data[0];
      else if (idx == CFG_WORLD_SCALE)
        scale = data;
    endfunction

    // ratio mode: coordinate times scale, floor shift 16, saturate to 32 bits; else raw
    function longint scaled(logic signed [31:0] v);
      longint p;
      longint q;
      if (!ratio_on)
        return longint'(v);
      p = longint'(v) * longint'({32'd0, scale});
      q = p >>> 16;
      if (q > 64'sd2147483647)
        q = 64'sd2147483647;
      if (q < -64'sd2147483648)
        q = -64'sd2147483648;
      return q;
    endfunction

    // floor(mag * inv / 2^18), saturated to the positive Q2.30 range
    function logic [31:0] term_of(logic [63:0] mag, logic [47:0] inv);
      logic [127:0] prod;
      prod = ({64'd0, mag} * {80'd0, inv}) >> 18;
      if (prod > 128'h7fff_ffff)
        return 32'h7fff_ffff;
      return prod[31:0];
    endfunction

    function void note_segment(segment_t s);
      longint xa, za, xb, zb, x1, z1, x2, z2, a, b, am, bm;
      logic [127:0] rad, root, trial;
      logic [127:0] quo;
      logic [31:0] smag;
      res_t e;
      xa = scaled(s.ax);
      za = scaled(s.az);
      xb = scaled(s.bx);
      zb = scaled(s.bz);
      // x order, a tie takes the second endpoint as first
      if (xa < xb) begin
        x1 = xa; z1 = za; x2 = xb; z2 = zb;
      end else begin
        x1 = xb; z1 = zb; x2 = xa; z2 = za;
      end
      a = z2 - z1;
      b = x1 - x2;
      e.min_x = x1[31:0];
      e.max_x = x2[31:0];
      e.min_z = (za < zb) ? za[31:0] : zb[31:0];
      e.max_z = (za < zb) ? zb[31:0] : za[31:0];
      e.coef_a = a[32:0];
      e.coef_b = b[32:0];
      e.coef_c = x2 * z1 - x1 * z2;
      e.zero_length = (a == 0 && b == 0);
      if (e.zero_length) begin
        e.coef_c = C_ONE;
        e.inv_length = INV_MAX;
        e.sine_term = '0;
        e.cosine_term = '0;
      end else begin
        am = (a < 0) ? -a : a;
        bm = (b < 0) ? -b : b;
        rad = ({64'd0, am[63:0]} * {64'd0, am[63:0]} + {64'd0, bm[63:0]} * {64'd0, bm[63:0]})
              << FRAC_SH;
        root = '0;
        for (int i = 47; i >= 0; i--) begin
          trial = root | (128'd1 << i);
          if (trial * trial <= rad)
            root = trial;
        end
        quo = (128'd1 << 63) / root;
        e.inv_length = (quo > {80'd0, INV_MAX}) ? INV_MAX : quo[47:0];
        smag = term_of(bm[63:0], e.inv_length);
        e.cosine_term = term_of(am[63:0], e.inv_length);
        // minus b times reciprocal, flipped again when a is negative
        e.sine_term = ((b > 0) != (a < 0)) ? -smag : smag;
      end
      pending.push_back(e);
    endfunction

    task report_mismatch(string field, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h expected %h at %0t", field, got, want, $realtime);
      errors++;
    endtask

    task check_result(res_t got);
      res_t want;
      if (pending.size() == 0) begin
        $display("unexpected result beat at %0t", $realtime);
        errors++;
      end else begin
        want = pending.pop_front();
        if (got.min_x !== want.min_x) report_mismatch("min_x", got.min_x, want.min_x);
        if (got.max_x !== want.max_x) report_mismatch("max_x", got.max_x, want.max_x);
        if (got.min_z !== want.min_z) report_mismatch("min_z", got.min_z, want.min_z);
        if (got.max_z !== want.max_z) report_mismatch("max_z", got.max_z, want.max_z);
        if (got.coef_a !== want.coef_a) report_mismatch("coef_a", got.coef_a, want.coef_a);
        if (got.coef_b !== want.coef_b) report_mismatch("coef_b", got.coef_b, want.coef_b);
        if (got.coef_c !== want.coef_c) report_mismatch("coef_c", got.coef_c, want.coef_c);
        if (got.inv_length !== want.inv_length)
          report_mismatch("inv_length", got.inv_length, want.inv_length);
        if (got.sine_term !== want.sine_term)
          report_mismatch("sine_term", got.sine_term, want.sine_term);
        if (got.cosine_term !== want.cosine_term)
          report_mismatch("cosine_term", got.cosine_term, want.cosine_term);
        if (got.zero_length !== want.zero_length)
          report_mismatch("zero_length", got.zero_length, want.zero_length);
      end
    endtask
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_DATA_W-1:0]   in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_DATA_W-1:0]  out_tdata;
  logic [0:0]             out_tuser;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  line_scoreboard lines;
  int  cycles = 0;
  // set by the stimulus to ask the receiver for one long hold-off
  logic hold_request = 1'b0;

  segment_line_coefficients DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // hard stop if the pipe hangs
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // result monitor: unpack the beat, zero_length rides in tuser
  always @(posedge clk) begin
    res_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.min_x       = out_tdata[31:0];
      got.max_x       = out_tdata[63:32];
      got.min_z       = out_tdata[95:64];
      got.max_z       = out_tdata[127:96];
      got.coef_a      = out_tdata[160:128];
      got.coef_b      = out_tdata[193:161];
      got.coef_c      = out_tdata[257:194];
      got.inv_length  = out_tdata[305:258];
      got.sine_term   = out_tdata[337:306];
      got.cosine_term = out_tdata[369:338];
      got.zero_length = out_tuser[0];
      lines.check_result(got);
    end
  end

  // receiver: mostly ready, short and occasional long stalls, one long hold-off on request
  initial begin
    int n;
    int pick;
    bit held;
    held = 1'b0;
    out_tready = 1'b0;
    forever begin
      if (hold_request && !held) begin
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
        held = 1'b1;
      end else begin
        pick = $urandom_range(0, 99);
        n = (pick < 60) ? $urandom_range(1, 30) : (pick < 95) ? $urandom_range(1, 3)
            : $urandom_range(20, 60);
        out_tready <= (pick < 60);
        repeat (n) @(posedge clk);
      end
    end
  end

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
      7: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      8: return $urandom_range(0, 1) ? 32'h0000_0000 : 32'hffff_ffff;
      default: return $urandom_range(0, 1) ? 32'h0001_0000 : -32'sd65536;
    endcase
  endfunction

  // random segment with coincident points and shared x or z mixed in
  function automatic segment_t pick_segment();
    segment_t s;
    s.ax = pick_coord();
    s.az = pick_coord();
    s.bx = pick_coord();
    s.bz = pick_coord();
    case ($urandom_range(0, 9))
      0: begin s.bx = s.ax; s.bz = s.az; end
      1: s.bx = s.ax;
      2: s.bz = s.az;
      3: begin s.bx = s.ax + $urandom_range(0, 4); s.bz = s.az - $urandom_range(0, 4); end
      default: ;
    endcase
    return s;
  endfunction

  task send_segment(segment_t s, bit allow_gap);
    int pick;
    in_tvalid <= 1'b1;
    in_tdata <= {s.bz, s.bx, s.az, s.ax};
    do @(posedge clk); while (!in_tready);
    lines.note_segment(s);
    if (allow_gap) begin
      pick = $urandom_range(0, 99);
      if (pick >= 70) begin
        in_tvalid <= 1'b0;
        repeat ((pick < 95) ? $urandom_range(1, 3) : $urandom_range(15, 50)) @(posedge clk);
      end
    end
  endtask

  task finish_burst();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // config writes only with the pipe empty
  task write_reg(logic [CFG_INDEX_W-1:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    lines.write_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task drain();
    while (lines.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task random_burst(int count);
    for (int i = 0; i < count; i++)
      send_segment(pick_segment(), 1'b1);
    finish_burst();
  endtask

  task directed_segments();
    segment_t list[$];
    list.push_back('{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000});
    list.push_back('{32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000});
    list.push_back('{32'sh0001_0000, 32'sh0002_0000, 32'sh0001_0000, 32'sh0002_0000});
    list.push_back('{32'sh0, 32'sh0, 32'sh0, 32'sh0});
    // x tie, the second endpoint leads
    list.push_back('{32'sh0003_0000, 32'sh0001_0000, 32'sh0003_0000, 32'sh0005_0000});
    list.push_back('{32'sh0003_0000, 32'sh0005_0000, 32'sh0003_0000, 32'sh0001_0000});
    // horizontal both ways
    list.push_back('{32'sh0, 32'sh0004_0000, 32'sh0006_0000, 32'sh0004_0000});
    list.push_back('{32'sh0006_0000, 32'sh0004_0000, 32'sh0, 32'sh0004_0000});
    // slopes of both signs, a negative
    list.push_back('{32'sh0, 32'sh0002_0000, 32'sh0002_0000, 32'sh0});
    list.push_back('{32'sh0, 32'sh0, 32'sh0002_0000, 32'sh0002_0000});
    // one lsb apart, reciprocal saturates
    list.push_back('{32'sh0, 32'sh0, 32'sh1, 32'sh0});
    list.push_back('{32'sh0, 32'sh0, 32'sh0, 32'sh1});
    list.push_back('{32'sh1, 32'sh1, 32'sh0, 32'sh0});
    list.push_back('{-32'sh1, 32'sh7fff_ffff, 32'sh0, 32'sh8000_0000});
    list.push_back('{32'shffff_ffff, 32'shffff_ffff, 32'shffff_ffff, 32'shffff_ffff});
    list.push_back('{32'sh8000_0000, 32'sh0, 32'sh8000_0000, 32'sh0});
    list.push_back('{32'sh5555_5555, 32'shaaaa_aaaa, 32'shaaaa_aaaa, 32'sh5555_5555});
    list.push_back('{32'sh1234_5678, -32'sh1234_5678, -32'sh0000_0100, 32'sh0765_4321});
    foreach (list[i])
      send_segment(list[i], i[0]);
    finish_burst();
  endtask

  initial begin
    lines = new();
    hold_request = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_RATIO_MODE;
    cfg_data = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset config: no scaling
    directed_segments();
    random_burst(120);
    drain();

    // ratio mode at unit scale, then the directed set scaled by extremes
    write_reg(CFG_RATIO_MODE, 32'h1);
    random_burst(80);
    drain();
    write_reg(CFG_WORLD_SCALE, 32'h0);
    directed_segments();
    random_burst(40);
    drain();
    write_reg(CFG_WORLD_SCALE, 32'hffff_ffff);
    directed_segments();
    random_burst(100);
    drain();
    write_reg(CFG_WORLD_SCALE, 32'h0000_8000);
    random_burst(80);
    drain();
    // undecoded index must leave both registers alone
    write_reg(CFG_UNUSED_INDEX, 32'hffff_fffe);
    write_reg(CFG_WORLD_SCALE, $urandom);
    random_burst(100);
    drain();

    // back to raw coordinates while the receiver holds off, so the input stalls
    write_reg(CFG_RATIO_MODE, 32'h0);
    hold_request = 1'b1;
    for (int i = 0; i < 150; i++)
      send_segment(pick_segment(), 1'b0);
    finish_burst();
    random_burst(60);
    drain();

    if (lines.errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
